// File: design/pps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, widths and helpers for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int NUM_PROCS = 8;

    localparam int ID_W    = 8;
    localparam int PRIO_W  = 8;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 20;

    localparam int SLOT_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int CNT_W  = $clog2(NUM_PROCS + 1);
    // tick never exceeds max arrival plus all bursts
    localparam int TICK_W = ARR_W + $clog2(NUM_PROCS + 1);
    localparam int RES_W  = (TICK_W > TIME_W) ? TICK_W : TIME_W;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remaining;
        logic [TICK_W-1:0]  first_run;
    } proc_rec_t;

    localparam int REC_W = $bits(proc_rec_t);

    typedef struct packed {
        logic clear;
        logic eval;
    } scan_ctrl_t;

    typedef struct packed {
        logic              best_found;
        logic [SLOT_W-1:0] best_slot;
        logic              has_next;
        logic [TICK_W-1:0] next_arrival;
    } scan_stat_t;

    function automatic logic [RES_W-1:0] to_res(input logic [TICK_W-1:0] value);
        to_res = RES_W'(value);
    endfunction

endpackage

// File: design/pps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/pps_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_scan
// Shared compare unit: takes one slot per cycle and tracks the best ready
// process and the earliest future arrival.
// ----------------------------------------------------------------------------
module pps_scan
    import pps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  scan_ctrl_t        ctrl,
    input  proc_rec_t         rec,
    input  logic [SLOT_W-1:0] slot,
    input  logic [TICK_W-1:0] tick,
    output scan_stat_t        stat
);

    logic              best_found_reg, best_found_next;
    logic [SLOT_W-1:0] best_slot_reg, best_slot_next;
    logic [PRIO_W-1:0] best_prio_reg, best_prio_next;
    logic              has_next_reg, has_next_next;
    logic [TICK_W-1:0] nxt_reg, nxt_next;
    logic [TICK_W-1:0] arr_ext;
    logic              live;

    assign arr_ext = TICK_W'(rec.arrival);
    assign live    = (rec.remaining != '0);

    always_comb begin
        best_found_next = best_found_reg;
        best_slot_next  = best_slot_reg;
        best_prio_next  = best_prio_reg;
        has_next_next   = has_next_reg;
        nxt_next        = nxt_reg;
        if (ctrl.clear) begin
            best_found_next = 1'b0;
            has_next_next   = 1'b0;
        end else if (ctrl.eval && live) begin
            if (arr_ext <= tick) begin
                // strict compare keeps the lowest slot on a tie
                if (!best_found_reg || (rec.prio < best_prio_reg)) begin
                    best_found_next = 1'b1;
                    best_slot_next  = slot;
                    best_prio_next  = rec.prio;
                end
            end else begin
                if (!has_next_reg || (arr_ext < nxt_reg)) begin
                    has_next_next = 1'b1;
                    nxt_next      = arr_ext;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_found_reg <= 1'b0;
            has_next_reg   <= 1'b0;
        end else begin
            best_found_reg <= best_found_next;
            has_next_reg   <= has_next_next;
        end
        best_slot_reg <= best_slot_next;
        best_prio_reg <= best_prio_next;
        nxt_reg       <= nxt_next;
    end

    assign stat.best_found   = best_found_reg;
    assign stat.best_slot    = best_slot_reg;
    assign stat.has_next     = has_next_reg;
    assign stat.next_arrival = nxt_reg;

endmodule

// File: design/preemptive_priority_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Loads process records, then runs a preemptive priority schedule and
// emits one word per completed process in completion order.
// ----------------------------------------------------------------------------
// Records are taken one per cycle into a slot RAM until the word marked last;
// s_ready then drops until the final result word has been taken. The schedule
// is event driven: each scheduling step scans all loaded slots through one
// shared compare unit (one RAM read per cycle), then takes a decide state
// and, when a process runs, an execute state that advances time to the next
// arrival or the process's completion. A completion builds the result in
// S_RES1 and S_RES2, then offers it in S_OUT until taken. A set of N records
// needs at most about 2N steps. No clearing pass after reset.
module preemptive_priority_scheduler
    import pps_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ID_W-1:0]     s_process_id,
    input  logic [PRIO_W-1:0]   s_priority_req,
    input  logic [ARR_W-1:0]    s_arrival_time,
    input  logic [BURST_W-1:0]  s_burst_time,
    input  logic                s_last_process,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [ID_W-1:0]     m_done_id,
    output logic [TIME_W-1:0]   m_completion_time,
    output logic [TIME_W-1:0]   m_turnaround_time,
    output logic [TIME_W-1:0]   m_waiting_time,
    output logic [TIME_W-1:0]   m_response_time,
    output logic                m_last_result
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_DECIDE,
        S_EXEC,
        S_RES1,
        S_RES2,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]     loaded_reg, loaded_next;
    logic [CNT_W-1:0]     completed_reg, completed_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [NUM_PROCS-1:0] started_reg, started_next;
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [SLOT_W-1:0]    rd_slot_reg, rd_slot_next;
    logic [TICK_W-1:0]    diff_reg, diff_next;

    logic [ARR_W-1:0]     r_arr_reg, r_arr_next;
    logic [BURST_W-1:0]   r_burst_reg, r_burst_next;
    logic [TICK_W-1:0]    r_first_reg, r_first_next;
    logic [RES_W-1:0]     tat_reg, tat_next;

    logic                 m_valid_reg, m_valid_next;
    logic [ID_W-1:0]      m_id_reg, m_id_next;
    logic [TIME_W-1:0]    m_comp_reg, m_comp_next;
    logic [TIME_W-1:0]    m_tat_reg, m_tat_next;
    logic [TIME_W-1:0]    m_wait_reg, m_wait_next;
    logic [TIME_W-1:0]    m_resp_reg, m_resp_next;
    logic                 m_last_reg, m_last_next;

    logic                 s_fire;
    logic                 issue;
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [SLOT_W-1:0]    ram_raddr;
    proc_rec_t            ram_wrec;
    proc_rec_t            ram_rrec;
    logic [REC_W-1:0]     ram_wdata;
    logic [REC_W-1:0]     ram_rdata;
    proc_rec_t            load_rec;
    proc_rec_t            exec_rec;
    logic [BURST_W-1:0]   rem_new;
    logic [TICK_W-1:0]    first_sel;
    scan_ctrl_t           scan_ctrl;
    scan_stat_t           scan_stat;
    logic                 start_scan;
    logic [RES_W-1:0]     res_comp;
    logic [RES_W-1:0]     res_tat;
    logic [RES_W-1:0]     res_resp;
    logic [RES_W-1:0]     res_wait;

    assign s_ready = (state_reg == S_LOAD);
    assign s_fire  = s_valid && s_ready;
    assign issue   = (state_reg == S_SCAN) && (scan_idx_reg != loaded_reg);

    assign ram_rrec = proc_rec_t'(ram_rdata);

    always_comb begin
        load_rec           = '0;
        load_rec.id        = s_process_id;
        load_rec.prio      = s_priority_req;
        load_rec.arrival   = s_arrival_time;
        load_rec.burst     = (s_burst_time == '0) ? BURST_W'(1) : s_burst_time;
        load_rec.remaining = load_rec.burst;
    end

    // execute step: run best to next arrival or to completion
    always_comb begin
        first_sel = started_reg[scan_stat.best_slot] ? ram_rrec.first_run : tick_reg;
        if (scan_stat.has_next && (diff_reg < TICK_W'(ram_rrec.remaining))) begin
            rem_new = ram_rrec.remaining - diff_reg[BURST_W-1:0];
        end else begin
            rem_new = '0;
        end
        exec_rec           = ram_rrec;
        exec_rec.remaining = rem_new;
        exec_rec.first_run = first_sel;
    end

    always_comb begin
        if (state_reg == S_EXEC) begin
            ram_we    = 1'b1;
            ram_waddr = scan_stat.best_slot;
            ram_wrec  = exec_rec;
        end else begin
            ram_we    = s_fire && (loaded_reg != CNT_W'(NUM_PROCS));
            ram_waddr = loaded_reg[SLOT_W-1:0];
            ram_wrec  = load_rec;
        end
        ram_raddr = (state_reg == S_SCAN) ? scan_idx_reg[SLOT_W-1:0] : scan_stat.best_slot;
    end

    assign ram_wdata = REC_W'(ram_wrec);

    assign res_comp = to_res(tick_reg);
    assign res_tat  = res_comp - RES_W'(r_arr_reg);
    assign res_resp = to_res(r_first_reg) - RES_W'(r_arr_reg);
    assign res_wait = tat_reg - RES_W'(r_burst_reg);

    always_comb begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        completed_next = completed_reg;
        tick_next      = tick_reg;
        started_next   = started_reg;
        scan_idx_next  = scan_idx_reg;
        rd_pend_next   = issue;
        rd_slot_next   = scan_idx_reg[SLOT_W-1:0];
        diff_next      = diff_reg;
        r_arr_next     = r_arr_reg;
        r_burst_next   = r_burst_reg;
        r_first_next   = r_first_reg;
        tat_next       = tat_reg;
        m_valid_next   = m_valid_reg;
        m_id_next      = m_id_reg;
        m_comp_next    = m_comp_reg;
        m_tat_next     = m_tat_reg;
        m_wait_next    = m_wait_reg;
        m_resp_next    = m_resp_reg;
        m_last_next    = m_last_reg;
        start_scan     = 1'b0;

        case (state_reg)
            S_LOAD: begin
                if (s_fire) begin
                    if (loaded_reg != CNT_W'(NUM_PROCS)) begin
                        loaded_next = loaded_reg + CNT_W'(1);
                    end
                    if (s_last_process) begin
                        start_scan = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (issue) begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end else if (!rd_pend_reg) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                diff_next = scan_stat.next_arrival - tick_reg;
                if (scan_stat.best_found) begin
                    state_next = S_EXEC;
                end else begin
                    tick_next  = scan_stat.next_arrival;
                    start_scan = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_EXEC: begin
                started_next[scan_stat.best_slot] = 1'b1;
                if (rem_new != '0) begin
                    tick_next  = scan_stat.next_arrival;
                    start_scan = 1'b1;
                    state_next = S_SCAN;
                end else begin
                    tick_next      = tick_reg + TICK_W'(ram_rrec.remaining);
                    completed_next = completed_reg + CNT_W'(1);
                    m_id_next      = ram_rrec.id;
                    r_arr_next     = ram_rrec.arrival;
                    r_burst_next   = ram_rrec.burst;
                    r_first_next   = first_sel;
                    state_next     = S_RES1;
                end
            end
            S_RES1: begin
                tat_next    = res_tat;
                m_comp_next = res_comp[TIME_W-1:0];
                m_tat_next  = res_tat[TIME_W-1:0];
                m_resp_next = res_resp[TIME_W-1:0];
                m_last_next = (completed_reg == loaded_reg);
                state_next  = S_RES2;
            end
            S_RES2: begin
                m_wait_next  = res_wait[TIME_W-1:0];
                m_valid_next = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (completed_reg == loaded_reg) begin
                        loaded_next    = '0;
                        completed_next = '0;
                        tick_next      = '0;
                        started_next   = '0;
                        state_next     = S_LOAD;
                    end else begin
                        start_scan = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase

        if (start_scan) begin
            scan_idx_next = '0;
        end
    end

    assign scan_ctrl.clear = start_scan;
    assign scan_ctrl.eval  = (state_reg == S_SCAN) && rd_pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            loaded_reg    <= '0;
            completed_reg <= '0;
            tick_reg      <= '0;
            started_reg   <= '0;
            scan_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            completed_reg <= completed_next;
            tick_reg      <= tick_next;
            started_reg   <= started_next;
            scan_idx_reg  <= scan_idx_next;
            rd_pend_reg   <= rd_pend_next;
            m_valid_reg   <= m_valid_next;
        end
        rd_slot_reg <= rd_slot_next;
        diff_reg    <= diff_next;
        r_arr_reg   <= r_arr_next;
        r_burst_reg <= r_burst_next;
        r_first_reg <= r_first_next;
        tat_reg     <= tat_next;
        m_id_reg    <= m_id_next;
        m_comp_reg  <= m_comp_next;
        m_tat_reg   <= m_tat_next;
        m_wait_reg  <= m_wait_next;
        m_resp_reg  <= m_resp_next;
        m_last_reg  <= m_last_next;
    end

    pps_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_PROCS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pps_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (scan_ctrl),
        .rec     (ram_rrec),
        .slot    (rd_slot_reg),
        .tick    (tick_reg),
        .stat    (scan_stat)
    );

    assign m_valid           = m_valid_reg;
    assign m_done_id         = m_id_reg;
    assign m_completion_time = m_comp_reg;
    assign m_turnaround_time = m_tat_reg;
    assign m_waiting_time    = m_wait_reg;
    assign m_response_time   = m_resp_reg;
    assign m_last_result     = m_last_reg;

`ifndef SYNTH
    a_valid_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (state_reg == S_OUT))
        else $error("result word valid outside output state");

    a_completed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        completed_reg <= loaded_reg)
        else $error("more completions than loaded processes");

    a_loaded_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_reg <= CNT_W'(NUM_PROCS))
        else $error("slot count beyond table depth");

    a_exec_has_best: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |-> scan_stat.best_found)
        else $error("execute step without a selected process");

    a_idle_has_next: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DECIDE) && !scan_stat.best_found) |-> scan_stat.has_next)
        else $error("idle step with no future arrival");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the preemptive priority scheduler against a tick-accurate schedule
// worked out in the bench. Directed sets cover field extremes, preemption,
// priority ties, idle ticks, zero burst and a full table. Random sets follow,
// with idle bursts on both channels and one pause until all words drain.
// ----------------------------------------------------------------------------
module testbench;
    import pps_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic               last;
    } proc_word_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] completion;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] response;
        logic              last;
    } done_word_t;

    // dense: heavy preemption and ties; full: whole field range; medium: spread
    typedef enum logic [1:0] {
        MIX_DENSE,
        MIX_FULL,
        MIX_MEDIUM
    } mix_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [ID_W-1:0]    s_process_id = '0;
    logic [PRIO_W-1:0]  s_priority_req = '0;
    logic [ARR_W-1:0]   s_arrival_time = '0;
    logic [BURST_W-1:0] s_burst_time = '0;
    logic               s_last_process = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [ID_W-1:0]    m_done_id;
    logic [TIME_W-1:0]  m_completion_time;
    logic [TIME_W-1:0]  m_turnaround_time;
    logic [TIME_W-1:0]  m_waiting_time;
    logic [TIME_W-1:0]  m_response_time;
    logic               m_last_result;

    proc_word_t  set_recs[NUM_PROCS];
    int unsigned set_count = 0;
    done_word_t  pending_done[$];

    bit          idling = 1'b1;
    int unsigned stall_left = 0;
    int unsigned records_loaded = 0;
    int unsigned records_dropped = 0;
    int unsigned sets_run = 0;
    int unsigned words_checked = 0;
    int unsigned mismatches = 0;

    preemptive_priority_scheduler dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_process_id      (s_process_id),
        .s_priority_req    (s_priority_req),
        .s_arrival_time    (s_arrival_time),
        .s_burst_time      (s_burst_time),
        .s_last_process    (s_last_process),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_done_id         (m_done_id),
        .m_completion_time (m_completion_time),
        .m_turnaround_time (m_turnaround_time),
        .m_waiting_time    (m_waiting_time),
        .m_response_time   (m_response_time),
        .m_last_result     (m_last_result)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Walks the loaded set tick by tick (event to event) and queues the
    // completion words in the order they finish.
    task automatic plan_schedule();
        int unsigned left[NUM_PROCS];
        int unsigned first_tick[NUM_PROCS];
        bit          started[NUM_PROCS];
        int unsigned tick;
        int unsigned nxt;
        int unsigned run;
        int unsigned burst;
        int unsigned tat;
        int unsigned finished;
        int          best;
        bit          has_next;
        done_word_t  w;
        for (int i = 0; i < set_count; i++) begin
            left[i] = (set_recs[i].burst == 0) ? 1 : 32'(set_recs[i].burst);
            started[i] = 1'b0;
        end
        tick = 0;
        finished = 0;
        while (finished < set_count) begin
            best = -1;
            has_next = 1'b0;
            nxt = 0;
            for (int i = 0; i < set_count; i++) begin
                if (left[i] != 0) begin
                    if (set_recs[i].arrival <= tick) begin
                        if (best < 0) best = i;
                        else if (set_recs[i].prio < set_recs[best].prio) best = i;
                    end else if (!has_next || set_recs[i].arrival < nxt) begin
                        has_next = 1'b1;
                        nxt = 32'(set_recs[i].arrival);
                    end
                end
            end
            if (best < 0) begin
                if (!has_next) break;
                tick = nxt;
            end else begin
                if (!started[best]) begin
                    started[best] = 1'b1;
                    first_tick[best] = tick;
                end
                run = left[best];
                if (has_next && nxt - tick < run) run = nxt - tick;
                left[best] -= run;
                tick += run;
                if (left[best] == 0) begin
                    finished++;
                    burst = (set_recs[best].burst == 0) ? 1 : 32'(set_recs[best].burst);
                    tat = tick - set_recs[best].arrival;
                    w.id = set_recs[best].id;
                    w.completion = TIME_W'(tick);
                    w.turnaround = TIME_W'(tat);
                    w.waiting = TIME_W'(tat - burst);
                    w.response = TIME_W'(first_tick[best] - set_recs[best].arrival);
                    w.last = (finished == set_count);
                    pending_done.push_back(w);
                end
            end
        end
        sets_run++;
        set_count = 0;
    endtask

    task automatic load_record(input proc_word_t r);
        if (set_count < NUM_PROCS) begin
            set_recs[set_count] = r;
            set_count++;
            records_loaded++;
        end else begin
            records_dropped++;
        end
        if (r.last) plan_schedule();
    endtask

    task automatic send_word(input logic [ID_W-1:0] id, input logic [PRIO_W-1:0] prio,
                             input logic [ARR_W-1:0] arrival,
                             input logic [BURST_W-1:0] burst, input logic last);
        int unsigned gap;
        proc_word_t  r;
        gap = 0;
        if (idling && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        r = '{id: id, prio: prio, arrival: arrival, burst: burst, last: last};
        s_valid <= 1'b1;
        s_process_id <= id;
        s_priority_req <= prio;
        s_arrival_time <= arrival;
        s_burst_time <= burst;
        s_last_process <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        load_record(r);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_done.size() != 0);
    endtask

    task automatic send_random_set(input int unsigned size, input mix_t mode);
        logic [PRIO_W-1:0]  prio;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        for (int unsigned i = 0; i < size; i++) begin
            case (mode)
                MIX_DENSE: begin
                    prio = PRIO_W'($urandom_range(0, 3));
                    arrival = ARR_W'($urandom_range(0, 20));
                    burst = BURST_W'($urandom_range(1, 10));
                end
                MIX_FULL: begin
                    prio = PRIO_W'($urandom_range(0, 255));
                    arrival = ARR_W'($urandom_range(0, 65535));
                    burst = BURST_W'($urandom_range(1, 65535));
                end
                default: begin
                    prio = PRIO_W'($urandom_range(0, 15));
                    arrival = ARR_W'($urandom_range(0, 255));
                    burst = BURST_W'($urandom_range(1, 300));
                end
            endcase
            send_word(ID_W'($urandom_range(0, 255)), prio, arrival, burst, i == size - 1);
        end
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("tb: %s mismatch: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        done_word_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_done.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected result word, id %0d", m_done_id);
            end else begin
                w = pending_done.pop_front();
                words_checked++;
                check_field("done_id", TIME_W'(w.id), TIME_W'(m_done_id));
                check_field("completion_time", w.completion, m_completion_time);
                check_field("turnaround_time", w.turnaround, m_turnaround_time);
                check_field("waiting_time", w.waiting, m_waiting_time);
                check_field("response_time", w.response, m_response_time);
                check_field("last_result", TIME_W'(w.last), TIME_W'(m_last_result));
            end
        end
    end

    task automatic test_field_extremes();
        send_word(8'h00, 8'h00, 16'h0000, 16'h0001, 1'b1);
        send_word(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
    endtask

    // idle ticks before the first arrival, preemption by a later arrival,
    // and equal priorities resolved by slot order
    task automatic test_preemption_and_ties();
        send_word(8'd1, 8'd5, 16'd3, 16'd10, 1'b0);
        send_word(8'd2, 8'd1, 16'd6, 16'd4, 1'b0);
        send_word(8'd3, 8'd5, 16'd3, 16'd2, 1'b0);
        send_word(8'd4, 8'd1, 16'd6, 16'd3, 1'b1);
    endtask

    task automatic test_zero_burst();
        send_word(8'd5, 8'd2, 16'd0, 16'd0, 1'b0);
        send_word(8'd6, 8'd2, 16'd0, 16'd3, 1'b1);
    endtask

    // two records beyond capacity; the dropped last word still starts the run
    task automatic test_table_full();
        for (int unsigned i = 0; i < NUM_PROCS + 2; i++)
            send_word(ID_W'(16 + i), PRIO_W'($urandom_range(0, 7)), ARR_W'(2 * i),
                      BURST_W'(i + 1), i == NUM_PROCS + 1);
    endtask

    task automatic test_drain_pause();
        send_random_set(4, MIX_DENSE);
        wait_drained();
        send_random_set(3, MIX_MEDIUM);
    endtask

    task automatic test_random_sets();
        int unsigned start;
        int unsigned size;
        start = records_loaded;
        while (records_loaded - start < 200) begin
            if (records_loaded - start >= 165) idling = 1'b0;
            else idling = ($urandom_range(0, 4) != 0);
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_PROCS + 1, NUM_PROCS + 3)
                                               : $urandom_range(1, NUM_PROCS);
            send_random_set(size, mix_t'($urandom_range(0, 2)));
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_field_extremes();
        test_preemption_and_ties();
        test_zero_burst();
        test_table_full();
        test_drain_pause();
        test_random_sets();
        wait_drained();
        repeat (60) @(posedge aclk);
        $display("tb: %0d schedules run over %0d loaded records (%0d dropped when full)",
                 sets_run, records_loaded, records_dropped);
        $display("tb: %0d completion words checked, %0d mismatches",
                 words_checked, mismatches);
        if (mismatches == 0 && pending_done.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/pps_pkg.sv
design/pps_ram.sv
design/pps_scan.sv
design/preemptive_priority_scheduler.sv
dv/testbench.sv
